/* rtl/assert_macros.svh */
// Assertion helpers shared by the rasteriser RTL.
// Both macros take a label, the clock, the active-low reset, a condition and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequence must hold in the cycle after the condition.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/dpor_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpor_pkg
// Shared codes, constants and the command and status bundles of the rasteriser.
// ----------------------------------------------------------------------------
package dpor_pkg;

    localparam int COLOR_BITS = 24;
    localparam logic [COLOR_BITS-1:0] COLOR_RESET = 24'hFFFFFF;

    // Request kinds.
    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_CLOSE  = 2'd1;
    localparam logic [1:0] KIND_STEP   = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
    localparam logic [1:0] STATUS_PIXEL    = 2'd1;
    localparam logic [1:0] STATUS_IDLE     = 2'd2;
    localparam logic [1:0] STATUS_REFUSED  = 2'd3;

    typedef struct packed {
        logic       load_out;
        logic [1:0] status;
        logic       seg_last;
        logic       poly_done;
        logic       store_first;
        logic       clear_first;
        logic       store_prev;
        logic       open_seg;
        logic       pixel_step;
        logic       set_closing;
        logic       clear_closing;
        logic       div_step;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       have_first;
        logic       busy;
        logic       last_step;
        logic       closing;
        logic       seg_zero;
        logic       div_last;
        logic       out_stall;
    } dp_stat_t;

endpackage

/* rtl/dpor_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpor_ctrl
// Request decoder and sequencer: accepts requests and runs the increment divider.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpor_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  dpor_pkg::dp_stat_t stat,
    output dpor_pkg::dp_cmd_t  cmd
);
    import dpor_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DIV  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE) && !stat.out_stall;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd        = '0;
        cmd.status = STATUS_IDLE;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load_out = 1'b1;
                    unique case (stat.kind) inside
                        KIND_VERTEX, KIND_CLOSE: begin
                            if (stat.busy) begin
                                cmd.status = STATUS_REFUSED;
                            end else if (stat.kind == KIND_VERTEX) begin
                                cmd.status     = STATUS_ACCEPTED;
                                cmd.store_prev = 1'b1;
                                if (!stat.have_first) begin
                                    cmd.store_first = 1'b1;
                                end else begin
                                    cmd.open_seg = 1'b1;
                                    if (!stat.seg_zero) begin
                                        state_next = ST_DIV;
                                    end
                                end
                            end else if (stat.have_first) begin
                                cmd.status      = STATUS_ACCEPTED;
                                cmd.open_seg    = 1'b1;
                                cmd.clear_first = 1'b1;
                                if (stat.seg_zero) begin
                                    cmd.poly_done     = 1'b1;
                                    cmd.clear_closing = 1'b1;
                                end else begin
                                    cmd.set_closing = 1'b1;
                                    state_next      = ST_DIV;
                                end
                            end
                        end
                        KIND_STEP: begin
                            if (stat.busy) begin
                                cmd.status     = STATUS_PIXEL;
                                cmd.pixel_step = 1'b1;
                                cmd.seg_last   = stat.last_step;
                                cmd.poly_done  = stat.last_step && stat.closing;
                                cmd.clear_closing = stat.last_step;
                            end
                        end
                        default: begin
                            cmd.status = STATUS_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `ASSERT_NEXT(a_open_divides, aclk, aresetn, cmd.open_seg && !stat.seg_zero, state_reg == ST_DIV)

endmodule

/* rtl/dpor_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpor_dp
// Datapath: polygon points, DDA accumulators, increment divider and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpor_dp #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  dpor_pkg::dp_cmd_t              cmd,
    output dpor_pkg::dp_stat_t             stat,
    input  logic [1:0]                     kind_in,
    input  logic [COORD_BITS-1:0]          vertex_x,
    input  logic [COORD_BITS-1:0]          vertex_y,
    input  logic                           cfg_wr_en,
    input  logic [dpor_pkg::COLOR_BITS-1:0] cfg_wr_data,
    input  logic                           m_tready,
    output logic                           out_valid,
    output logic [1:0]                     out_status,
    output logic [COORD_BITS-1:0]          out_px,
    output logic [COORD_BITS-1:0]          out_py,
    output logic [dpor_pkg::COLOR_BITS-1:0] out_color,
    output logic                           out_last,
    output logic                           out_done
);
    import dpor_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int F      = FRAC_BITS;
    localparam int ACC_W  = C + F + 1;
    localparam int STEP_W = F + 2;
    localparam int Q_W    = F + 1;
    localparam int CNT_W  = $clog2(F + 1);

    logic                  have_first_reg;
    logic [2*C-1:0]        first_reg;
    logic [2*C-1:0]        prev_reg;
    logic [C-1:0]          steps_left_reg;
    logic                  closing_reg;
    logic [COLOR_BITS-1:0] color_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  out_valid_reg;

    logic [ACC_W-1:0]      acc_x_reg, acc_y_reg;
    logic [STEP_W-1:0]     step_x_reg, step_y_reg;
    logic [C:0]            rx_reg, ry_reg;
    logic [Q_W-1:0]        qx_reg, qy_reg;
    logic [C-1:0]          div_reg;
    logic                  neg_x_reg, neg_y_reg;

    logic [1:0]            out_status_reg;
    logic [C-1:0]          out_px_reg, out_py_reg;
    logic [COLOR_BITS-1:0] out_color_reg;
    logic                  out_last_reg, out_done_reg;

    // Segment set-up.
    logic [2*C-1:0] p_in, to_pt;
    logic [C-1:0]   x0, y0, x1, y1;
    logic [C:0]     dx, dy, ndx, ndy;
    logic [C-1:0]   ax, ay, steps;

    assign p_in  = {vertex_y, vertex_x};
    assign to_pt = (kind_in == KIND_CLOSE) ? first_reg : p_in;
    assign x0    = prev_reg[C-1:0];
    assign y0    = prev_reg[2*C-1:C];
    assign x1    = to_pt[C-1:0];
    assign y1    = to_pt[2*C-1:C];
    assign dx    = {1'b0, x1} - {1'b0, x0};
    assign dy    = {1'b0, y1} - {1'b0, y0};
    assign ndx   = -dx;
    assign ndy   = -dy;
    assign ax    = dx[C] ? ndx[C-1:0] : dx[C-1:0];
    assign ay    = dy[C] ? ndy[C-1:0] : dy[C-1:0];
    assign steps = (ax > ay) ? ax : ay;

    // One restoring division step per lane; the remainder always stays below the divisor.
    logic [C+1:0]     diff_x, diff_y;
    logic             ge_x, ge_y;
    logic [C:0]       rem_x, rem_y;
    logic [Q_W-1:0]   qx_next, qy_next;
    logic [STEP_W-1:0] mag_x, mag_y;

    assign diff_x  = {1'b0, rx_reg} - {2'b00, div_reg};
    assign diff_y  = {1'b0, ry_reg} - {2'b00, div_reg};
    assign ge_x    = !diff_x[C+1];
    assign ge_y    = !diff_y[C+1];
    assign rem_x   = ge_x ? diff_x[C:0] : rx_reg;
    assign rem_y   = ge_y ? diff_y[C:0] : ry_reg;
    assign qx_next = {qx_reg[Q_W-2:0], ge_x};
    assign qy_next = {qy_reg[Q_W-2:0], ge_y};
    assign mag_x   = {1'b0, qx_next};
    assign mag_y   = {1'b0, qy_next};

    // Accumulators carry the half-pixel bias, so rounding is a plain field select.
    logic [ACC_W-1:0] acc_x_next, acc_y_next;
    logic [C-1:0]     px, py;

    assign acc_x_next = acc_x_reg + {{(ACC_W-STEP_W){step_x_reg[STEP_W-1]}}, step_x_reg};
    assign acc_y_next = acc_y_reg + {{(ACC_W-STEP_W){step_y_reg[STEP_W-1]}}, step_y_reg};
    assign px = acc_x_next[ACC_W-1] ? '0 : acc_x_next[F+C-1:F];
    assign py = acc_y_next[ACC_W-1] ? '0 : acc_y_next[F+C-1:F];

    always_comb begin
        stat            = '0;
        stat.kind       = kind_in;
        stat.have_first = have_first_reg;
        stat.busy       = (steps_left_reg != '0);
        stat.last_step  = (steps_left_reg == C'(1));
        stat.closing    = closing_reg;
        stat.seg_zero   = (steps == '0);
        stat.div_last   = (cnt_reg == CNT_W'(F));
        stat.out_stall  = out_valid_reg && !m_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_first_reg <= 1'b0;
            first_reg      <= '0;
            prev_reg       <= '0;
            steps_left_reg <= '0;
            closing_reg    <= 1'b0;
            color_reg      <= COLOR_RESET;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                color_reg <= cfg_wr_data;
            end
            if (cmd.store_first) begin
                first_reg      <= p_in;
                have_first_reg <= 1'b1;
            end
            if (cmd.clear_first) begin
                have_first_reg <= 1'b0;
            end
            if (cmd.store_prev) begin
                prev_reg <= p_in;
            end
            if (cmd.open_seg) begin
                steps_left_reg <= steps;
                cnt_reg        <= '0;
            end
            if (cmd.div_step) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.pixel_step) begin
                steps_left_reg <= steps_left_reg - C'(1);
            end
            if (cmd.set_closing) begin
                closing_reg <= 1'b1;
            end
            if (cmd.clear_closing) begin
                closing_reg <= 1'b0;
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.open_seg) begin
            acc_x_reg <= {1'b0, x0, 1'b1, {(F-1){1'b0}}};
            acc_y_reg <= {1'b0, y0, 1'b1, {(F-1){1'b0}}};
            rx_reg    <= {1'b0, ax};
            ry_reg    <= {1'b0, ay};
            div_reg   <= steps;
            neg_x_reg <= dx[C];
            neg_y_reg <= dy[C];
            qx_reg    <= '0;
            qy_reg    <= '0;
        end
        if (cmd.div_step) begin
            rx_reg <= {rem_x[C-1:0], 1'b0};
            ry_reg <= {rem_y[C-1:0], 1'b0};
            qx_reg <= qx_next;
            qy_reg <= qy_next;
            if (stat.div_last) begin
                step_x_reg <= neg_x_reg ? -mag_x : mag_x;
                step_y_reg <= neg_y_reg ? -mag_y : mag_y;
            end
        end
        if (cmd.pixel_step) begin
            acc_x_reg <= acc_x_next;
            acc_y_reg <= acc_y_next;
        end
        if (cmd.load_out) begin
            out_status_reg <= cmd.status;
            out_last_reg   <= cmd.seg_last;
            out_done_reg   <= cmd.poly_done;
            out_px_reg     <= cmd.pixel_step ? px : '0;
            out_py_reg     <= cmd.pixel_step ? py : '0;
            out_color_reg  <= cmd.pixel_step ? color_reg : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_px     = out_px_reg;
    assign out_py     = out_py_reg;
    assign out_color  = out_color_reg;
    assign out_last   = out_last_reg;
    assign out_done   = out_done_reg;

    `ASSERT_IMPLIES(a_pixel_needs_seg, aclk, aresetn, cmd.pixel_step, steps_left_reg != '0)
    `ASSERT_IMPLIES(a_open_when_free, aclk, aresetn, cmd.open_seg, steps_left_reg == '0)
    `ASSERT_NEXT(a_last_pixel_ends, aclk, aresetn, cmd.pixel_step && stat.last_step, (steps_left_reg == '0) && !closing_reg)

endmodule

/* rtl/dda_polygon_outline_rasterizer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_polygon_outline_rasterizer_top
// Closed polygon outline drawing with a DDA line generator on stream ports.
// ----------------------------------------------------------------------------
// Every request gives exactly one result. A vertex request adds a corner and,
// from the second corner on, opens a segment from the previous corner; a close
// request opens the segment back to the first corner and clears the polygon.
// Each step request then yields one pixel of the open segment, the start pixel
// being skipped, so a segment of length max(|dx|,|dy|) gives that many pixels
// and ends on its far corner. Step requests may follow one another in
// consecutive cycles while the result channel does not stall. A vertex or
// close request that opens a segment of non-zero length is answered at once,
// but the input then stalls while the restoring divider works out both
// per-step increments, one quotient bit per cycle. No other request starts
// the divider. Results sit in an output register, so a new request may be taken
// in the same cycle as the previous result leaves. The pixel colour register
// may be written at any idle moment and takes effect on the next pixel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dda_polygon_outline_rasterizer_top #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  logic aclk,
    input  logic aresetn,

    // Input request channel.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata, lowest bit up: vertex_x, vertex_y, zero fill.
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]   s_tdata,
    // tuser, lowest bit up: kind.
    input  logic [1:0]                          s_tuser,

    // Result channel.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata, lowest bit up: pixel_x, pixel_y, color, zero fill.
    output logic [((2*COORD_BITS+dpor_pkg::COLOR_BITS+7)/8)*8-1:0] m_tdata,
    // tuser, lowest bit up: status, polygon_done.
    output logic [2:0]                          m_tuser,
    // tlast carries segment_last.
    output logic                                m_tlast,

    // Pixel colour register.
    input  logic                                cfg_wr_en,
    input  logic [dpor_pkg::COLOR_BITS-1:0]     cfg_wr_data
);
    import dpor_pkg::*;

    localparam int OUT_W = ((2*COORD_BITS+COLOR_BITS+7)/8)*8;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    logic [1:0]            out_status;
    logic [COORD_BITS-1:0] out_px, out_py;
    logic [COLOR_BITS-1:0] out_color;
    logic                  out_last, out_done;

    // The controller decodes each request and sequences the divider.
    dpor_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the polygon, the segment state and the result register.
    dpor_dp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .kind_in     (s_tuser),
        .vertex_x    (s_tdata[COORD_BITS-1:0]),
        .vertex_y    (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tready    (m_tready),
        .out_valid   (m_tvalid),
        .out_status  (out_status),
        .out_px      (out_px),
        .out_py      (out_py),
        .out_color   (out_color),
        .out_last    (out_last),
        .out_done    (out_done)
    );

    assign m_tdata = OUT_W'({out_color, out_py, out_px});
    assign m_tuser = {out_done, out_status};
    assign m_tlast = out_last;

    // A segment-last result always carries the pixel status; polygon completion only ends a segment
    // or answers a close request.
    `ASSERT_IMPLIES(a_last_is_pixel, aclk, aresetn, m_tvalid && m_tlast, out_status == STATUS_PIXEL)
    `ASSERT_IMPLIES(a_done_placed, aclk, aresetn, m_tvalid && out_done, m_tlast || (out_status == STATUS_ACCEPTED))

endmodule
